[rtl/pli_pkg.sv]
// Shared constants for the positional list: sizes, operation and status codes.
package pli_pkg;

   localparam int CAPACITY = 16;

   // Index into the list store, and a count that can hold CAPACITY itself
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Fixed item field widths
   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 5;

   // Width for comparing a position against the element count
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_DELETE = 2'd1;
   localparam op_type OP_READ   = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_RANGE = 2'd2;
   localparam status_type ST_FULL  = 2'd3;

endpackage

[rtl/positional_list_insert_delete.sv]
// Positional list: an ordered list of signed values held in a synchronous memory.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit values in a
// single-port-write, single-port-read memory whose read data is registered and
// arrives in the cycle after the address. It takes one request item at a time.
// An insert puts the value at req_position (or appends it when the position is
// at or past the end) by moving the tail up one place, one element per cycle,
// then writing the new value. A delete moves the tail down one place, one
// element per cycle. A read-out emits each element as its own result item,
// each through a memory read, then an output load, with rsp_last on the
// final one. An insert into a full list returns status full, a delete on an
// empty list or past the end returns empty or out of range, and a read-out of
// an empty list returns one item with status empty. Every other result carries
// element zero, and rsp_length always gives the count after the operation.
// Besides the work above, each item is taken in the idle state and each of its
// results is loaded into the output stage; a stalled result channel holds the
// block for as long as the output stage stays full.
// The memory move loop sets the cost of insert and delete; the single read port
// sets the read-out rate. A registered output stage holds the last result while
// the next request is taken. The store needs no clearing after reset: only
// entries below the element count are ever read.
module positional_list_insert_delete (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic signed [31:0] req_value,
   input  logic [7:0]  req_position,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic signed [31:0] rsp_element,
   output logic        rsp_last,
   output logic [4:0]  rsp_length
);

   localparam int IDX_W = pli_pkg::IDX_W;
   localparam int CNT_W = pli_pkg::CNT_W;
   localparam int CMP_W = pli_pkg::CMP_W;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_INS     = 3'd1;
   localparam logic [2:0] S_DEL     = 3'd2;
   localparam logic [2:0] S_RD_ADDR = 3'd3;
   localparam logic [2:0] S_RD_EMIT = 3'd4;
   localparam logic [2:0] S_DONE    = 3'd5;

   // list store
   logic [pli_pkg::VALUE_W-1:0] cells_mem [pli_pkg::CAPACITY];
   logic [pli_pkg::VALUE_W-1:0] rd_data_ff;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [pli_pkg::VALUE_W-1:0] wr_data;
   logic                        rd_en;
   logic [IDX_W-1:0]            rd_addr;

   // sequencer state
   logic [2:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            cur_ff, cur_in;      // move / read cursor
   logic [IDX_W-1:0]            pos_ff, pos_in;      // target place of insert
   logic [IDX_W-1:0]            wdest_ff, wdest_in;  // destination of a pending move
   logic                        pend_ff, pend_in;    // a move read is in flight
   logic [pli_pkg::VALUE_W-1:0] val_ff, val_in;
   pli_pkg::status_type         st_ff, st_in;

   // output stage
   logic                        rsp_valid_ff, rsp_valid_in;
   pli_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [pli_pkg::VALUE_W-1:0] rsp_element_ff, rsp_element_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic [pli_pkg::LENGTH_W-1:0] rsp_length_ff, rsp_length_in;

   logic                        out_free;
   logic                        rsp_load;
   logic                        accept;
   logic [CMP_W-1:0]            pos_wide;
   logic [CMP_W-1:0]            cnt_wide;
   logic                        rd_is_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign pos_wide  = CMP_W'(req_position);
   assign cnt_wide  = CMP_W'(count_ff);
   assign rd_is_last = (CNT_W'(cur_ff) + CNT_W'(1)) == count_ff;

   // memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells_mem[rd_addr];
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      cur_in         = cur_ff;
      pos_in         = pos_ff;
      wdest_in       = wdest_ff;
      pend_in        = pend_ff;
      val_in         = val_ff;
      st_in          = st_ff;
      wr_en          = 1'b0;
      wr_addr        = wdest_ff;
      wr_data        = rd_data_ff;
      rd_en          = 1'b0;
      rd_addr        = cur_ff;
      rsp_load       = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_in = 1'b0;
               case (req_operation)
                  pli_pkg::OP_INSERT: begin
                     if (count_ff >= CNT_W'(pli_pkg::CAPACITY)) begin
                        st_in    = pli_pkg::ST_FULL;
                        state_in = S_DONE;
                     end else begin
                        // append when the position is at or past the end
                        cur_in   = IDX_W'(count_ff);
                        pos_in   = (pos_wide > cnt_wide) ? IDX_W'(count_ff)
                                                         : IDX_W'(req_position);
                        val_in   = req_value;
                        state_in = S_INS;
                     end
                  end
                  pli_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        st_in    = pli_pkg::ST_EMPTY;
                        state_in = S_DONE;
                     end else if (pos_wide >= cnt_wide) begin
                        st_in    = pli_pkg::ST_RANGE;
                        state_in = S_DONE;
                     end else begin
                        cur_in   = IDX_W'(req_position);
                        state_in = S_DEL;
                     end
                  end
                  pli_pkg::OP_READ: begin
                     if (count_ff == '0) begin
                        st_in    = pli_pkg::ST_EMPTY;
                        state_in = S_DONE;
                     end else begin
                        cur_in   = '0;
                        state_in = S_RD_ADDR;
                     end
                  end
                  default: begin
                     st_in    = pli_pkg::ST_OK;
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_INS: begin
            // retire the move read last cycle
            if (pend_ff) begin
               wr_en   = 1'b1;
               pend_in = 1'b0;
            end
            if (cur_ff > pos_ff) begin
               rd_en    = 1'b1;
               rd_addr  = cur_ff - IDX_W'(1);
               wdest_in = cur_ff;
               pend_in  = 1'b1;
               cur_in   = cur_ff - IDX_W'(1);
            end else if (!pend_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = val_ff;
               count_in = count_ff + CNT_W'(1);
               st_in    = pli_pkg::ST_OK;
               state_in = S_DONE;
            end
         end

         S_DEL: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               pend_in = 1'b0;
            end
            if ((CNT_W'(cur_ff) + CNT_W'(1)) < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = cur_ff + IDX_W'(1);
               wdest_in = cur_ff;
               pend_in  = 1'b1;
               cur_in   = cur_ff + IDX_W'(1);
            end else if (!pend_ff) begin
               count_in = count_ff - CNT_W'(1);
               st_in    = pli_pkg::ST_OK;
               state_in = S_DONE;
            end
         end

         S_RD_ADDR: begin
            rd_en    = 1'b1;
            rd_addr  = cur_ff;
            state_in = S_RD_EMIT;
         end

         S_RD_EMIT: begin
            // hold the read data until the output stage frees up
            if (out_free) begin
               rsp_load       = 1'b1;
               rsp_status_in  = pli_pkg::ST_OK;
               rsp_element_in = rd_data_ff;
               rsp_last_in    = rd_is_last;
               if (rd_is_last) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in   = cur_ff + IDX_W'(1);
                  state_in = S_RD_ADDR;
               end
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_load       = 1'b1;
               rsp_status_in  = st_ff;
               rsp_element_in = '0;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_length_in = rsp_load ? pli_pkg::LENGTH_W'(count_ff) : rsp_length_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      pos_ff         <= pos_in;
      wdest_ff       <= wdest_in;
      val_ff         <= val_in;
      st_ff          <= st_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_length_ff  <= rsp_length_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_length  = rsp_length_ff;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the positional list: directed and random list traffic.
module tb_top;
   import pli_pkg::*;

   // Operation code with no defined list action; the block answers it with a plain ok
   localparam op_type OP_NOP = 2'd3;

   // Give up once this many cycles pass with no item moving on either channel
   localparam int QUIET_LIMIT = 3000;
   // Cycles to let pass after the last result before closing the run
   localparam int TAIL_CYCLES = 50;

   typedef logic signed [VALUE_W-1:0] value_t;

   typedef struct {
      status_type           status;
      value_t               element;
      logic                 last;
      logic [LENGTH_W-1:0]  length;
   } list_result_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   op_type               req_operation = OP_INSERT;
   value_t               req_value = '0;
   logic [POS_W-1:0]     req_position = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   status_type           rsp_status;
   value_t               rsp_element;
   logic                 rsp_last;
   logic [LENGTH_W-1:0]  rsp_length;

   // Predicted list contents, updated as each request item is taken
   value_t        shadow_list[$];
   // Results still owed by the block, oldest first
   list_result_t  pending_results[$];

   int  error_count = 0;
   int  quiet_cycles = 0;
   int  rsp_hold = 0;
   // Clear to run both channels flat out
   bit  idle_on = 1'b1;

   positional_list_insert_delete DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_element   (rsp_element),
      .rsp_last      (rsp_last),
      .rsp_length    (rsp_length)
   );

   always #10 clock = ~clock;

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 20);
   endfunction

   // Pick one of the corner values of a signed 32-bit word
   function automatic value_t corner_value();
      case ($urandom_range(0, 3))
         0:       return value_t'(32'h8000_0000);
         1:       return value_t'(32'h7FFF_FFFF);
         2:       return value_t'(32'hFFFF_FFFF);
         default: return '0;
      endcase
   endfunction

   // Append one owed result; length is the count after the operation, low bits only
   function automatic void queue_result(input status_type status, input value_t element,
                                        input logic last);
      list_result_t r;
      r.status  = status;
      r.element = element;
      r.last    = last;
      r.length  = LENGTH_W'(shadow_list.size());
      pending_results.push_back(r);
   endfunction

   // Apply one request item to the shadow list and queue the results it causes
   function automatic void apply_list_op(input op_type op, input value_t val,
                                         input logic [POS_W-1:0] pos);
      int count;
      int at;
      count = shadow_list.size();
      case (op)
         OP_INSERT: begin
            // drop the value when full; clamp a far position to an append
            if (count >= CAPACITY) begin
               queue_result(ST_FULL, '0, 1'b1);
            end else begin
               at = (pos > count) ? count : pos;
               shadow_list.insert(at, val);
               queue_result(ST_OK, '0, 1'b1);
            end
         end
         OP_DELETE: begin
            if (count == 0) begin
               queue_result(ST_EMPTY, '0, 1'b1);
            end else if (pos >= count) begin
               queue_result(ST_RANGE, '0, 1'b1);
            end else begin
               shadow_list.delete(pos);
               queue_result(ST_OK, '0, 1'b1);
            end
         end
         OP_READ: begin
            // one result per element, last flag on the final one
            if (count == 0)
               queue_result(ST_EMPTY, '0, 1'b1);
            else
               for (int i = 0; i < count; i++)
                  queue_result(ST_OK, shadow_list[i], i == count - 1);
         end
         default: begin
            queue_result(ST_OK, '0, 1'b1);
         end
      endcase
   endfunction

   function automatic void compare_field(input string field, input logic signed [32:0] want_v,
                                         input logic signed [32:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
         error_count++;
      end
   endfunction

   // Observe both channels on the edge: predict taken requests, then check taken results.
   // Everything here reads the values held just before the edge.
   always @(posedge clock) begin
      list_result_t want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_valid && req_ready)
            apply_list_op(req_operation, req_value, req_position);
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none actual status %0d element %0d",
                        $time, rsp_status, rsp_element);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               compare_field("status", 33'(want.status), 33'(rsp_status));
               compare_field("element", 33'(want.element), 33'(rsp_element));
               compare_field("last", 33'(want.last), 33'(rsp_last));
               compare_field("length", 33'(want.length), 33'(rsp_length));
            end
         end
         // count cycles in which neither channel moves an item
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   // Result side: after each item taken, maybe stall for a while; drop ready now and then
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         rsp_hold = pick_gap();
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Send one request item after an optional gap; return on the edge that takes it.
   // Valid stays high on return so a following item can go out with no bubble.
   task automatic send_item(input op_type op, input value_t val, input logic [POS_W-1:0] pos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= val;
      req_position  <= pos;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold the sender until every owed result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Empty list: read-out, deletes at both ends of the position range, unused opcode
   task automatic test_empty_list();
      send_item(OP_READ, value_t'(32'h1234_5678), 8'd0);
      send_item(OP_DELETE, '0, 8'd0);
      send_item(OP_DELETE, '1, 8'd255);
      send_item(OP_NOP, '1, 8'd255);
   endtask

   // Corner values at front, far end and middle; out-of-range delete; middle delete
   task automatic test_value_extremes();
      send_item(OP_INSERT, value_t'(32'h8000_0000), 8'd0);
      send_item(OP_INSERT, value_t'(32'h7FFF_FFFF), 8'd255);
      send_item(OP_INSERT, '0, 8'd1);
      send_item(OP_INSERT, '1, 8'd0);
      send_item(OP_READ, '0, 8'd0);
      send_item(OP_DELETE, '0, 8'd255);
      send_item(OP_NOP, value_t'(32'h5A5A_5A5A), 8'd3);
      send_item(OP_DELETE, '0, 8'd1);
      send_item(OP_READ, '1, 8'd255);
   endtask

   // Fill to capacity, insert into the full list, read it all, trim both ends
   task automatic test_full_list();
      drain_results();
      while (shadow_list.size() < CAPACITY)
         send_item(OP_INSERT, $urandom,
                   POS_W'($urandom_range(0, shadow_list.size() + 2)));
      send_item(OP_INSERT, value_t'(32'hDEAD_BEEF), 8'd0);
      send_item(OP_READ, '0, 8'd0);
      send_item(OP_DELETE, '0, 8'd0);
      send_item(OP_DELETE, '0, POS_W'(CAPACITY - 2));
      drain_results();
   endtask

   // Random list traffic; phases of 40 items alternate between growing and shrinking
   // so the list swings between empty and full
   task automatic test_random_traffic(input int n_items);
      op_type            op;
      value_t            val;
      logic [POS_W-1:0]  pos;
      int                r;
      int                p_ins;
      int                p_del;
      for (int k = 0; k < n_items; k++) begin
         if ((k / 40) % 2 == 0) begin
            p_ins = 65;
            p_del = 85;
         end else begin
            p_ins = 20;
            p_del = 85;
         end
         r = $urandom_range(0, 99);
         if (r < p_ins)
            op = OP_INSERT;
         else if (r < p_del)
            op = OP_DELETE;
         else if (r < 97)
            op = OP_READ;
         else
            op = OP_NOP;
         // mostly near or inside the list, some anywhere in the field
         r = $urandom_range(0, 99);
         if (r < 70)
            pos = POS_W'($urandom_range(0, shadow_list.size() + 1));
         else if (r < 85)
            pos = POS_W'($urandom_range(0, 255));
         else
            pos = (r < 92) ? 8'd255 : POS_W'(shadow_list.size());
         val = ($urandom_range(0, 4) == 0) ? corner_value() : value_t'($urandom);
         send_item(op, val, pos);
         if (k % 60 == 59)
            drain_results();
      end
   endtask

   // Both channels with no idling at all
   task automatic test_back_to_back(input int n_items);
      idle_on = 1'b0;
      test_random_traffic(n_items);
      drain_results();
      idle_on = 1'b1;
   endtask

   // Watchdog: end the run when nothing moves for too long
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_value_extremes();
      test_full_list();
      test_random_traffic(180);
      test_back_to_back(40);

      // wait out every owed result, then give the block time to show anything extra
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

[positional_list_insert_delete.f]
rtl/pli_pkg.sv
rtl/positional_list_insert_delete.sv
verif/tb_top.sv
